// File: rtl/core/ansi_escape_terminal_parser_macros.svh
// ============================================================================
// Assertion macros for the terminal parser
// Clocked, reset-gated property checks that report by $error.
// ============================================================================
`ifndef ANSI_ESCAPE_TERMINAL_PARSER_MACROS_SVH
`define ANSI_ESCAPE_TERMINAL_PARSER_MACROS_SVH

// same-cycle implication
`define AETP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// next-cycle implication
`define AETP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

// File: rtl/core/aetp_pkg.sv
// ============================================================================
// Terminal parser package
// Character codes, action codes, result type and the ANSI colour table.
// ============================================================================
package aetp_pkg;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_QUERY    = 8'h3F;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LOWER_M  = 8'h6D;
    localparam logic [7:0] CH_UPPER_J  = 8'h4A;
    localparam logic [7:0] CH_UPPER_H  = 8'h48;

    localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;
    localparam logic [31:0] ERASE_RESET = 32'hFF00_0000;
    localparam logic [15:0] PARAM_MAX   = 16'hFFFF;
    localparam logic [15:0] PARAM_CLEAR = 16'd2;

    typedef enum logic [1:0] {
        ACT_PRINT = 2'd0,
        ACT_ERASE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_HOME  = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [7:0]  char_code;
        logic [31:0] draw_color;
        logic        last;
    } t_result;

    function automatic logic [31:0] color_of(input logic [15:0] code);
        logic [31:0] col;
        case (code)
            16'd30:  col = 32'hFF11_1111;
            16'd31:  col = 32'hFFFF_5555;
            16'd32:  col = 32'hFF55_FF55;
            16'd33:  col = 32'hFFFF_FF55;
            16'd34:  col = 32'hFF55_55FF;
            16'd35:  col = 32'hFFFF_55FF;
            16'd36:  col = 32'hFF55_FFFF;
            16'd90:  col = 32'hFF88_8888;
            16'd91:  col = 32'hFFFF_8888;
            16'd92:  col = 32'hFF88_FF88;
            16'd93:  col = 32'hFFFF_FF88;
            16'd94:  col = 32'hFF88_88FF;
            16'd95:  col = 32'hFFFF_88FF;
            16'd96:  col = 32'hFF88_FFFF;
            default: col = COLOR_WHITE;
        endcase
        return col;
    endfunction

endpackage

// File: rtl/core/ansi_escape_terminal_parser.sv
// ============================================================================
// ANSI escape terminal parser
// Turns a character byte stream into print, erase, clear and home actions.
// ============================================================================
// Each result beat is written to the result queue when its byte is accepted.
// Throughput: one byte per cycle; ESC followed by a non-bracket byte gives two
// result beats, and the output side drains one beat per cycle while i_out_ready
// is high from a four-entry queue; input stalls when it holds over two beats.
// Reset: synchronous, active low; normal state, white foreground, queue empty.
`include "ansi_escape_terminal_parser_macros.svh"

module ansi_escape_terminal_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [7:0]  o_char_code,
    output logic [31:0] o_draw_color,
    output logic        o_last
);

    localparam int DEPTH = 4;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_ESC    = 2'd1,
        ST_CSI    = 2'd2
    } t_parse_state;

    t_parse_state        r_state, n_state;
    logic [15:0]         r_param, n_param;
    logic [31:0]         r_fg, n_fg;
    logic [31:0]         r_erase;
    logic [CW-1:0]       r_cnt, n_cnt;
    aetp_pkg::t_result   r_q [DEPTH];
    aetp_pkg::t_result   n_q [DEPTH];

    aetp_pkg::t_result   res0, res1;
    logic [1:0]          res_cnt;
    logic                accept;
    logic                pop;
    logic [CW-1:0]       base;
    logic [19:0]         digit_sum;

    assign o_in_ready = (r_cnt <= CW'(DEPTH - 2));
    assign accept     = i_in_valid && o_in_ready;
    assign pop        = (r_cnt != '0) && i_out_ready;

    assign o_out_valid  = (r_cnt != '0);
    assign o_action     = r_q[0].action;
    assign o_char_code  = r_q[0].char_code;
    assign o_draw_color = r_q[0].draw_color;
    assign o_last       = r_q[0].last;

    assign digit_sum = ({4'd0, r_param} << 3) + ({4'd0, r_param} << 1)
                     + {16'd0, i_char_byte[3:0]};

    always_comb begin
        n_state = r_state;
        n_param = r_param;
        n_fg    = r_fg;
        res_cnt = 2'd0;
        res0    = '{aetp_pkg::ACT_PRINT, i_char_byte, r_fg, 1'b1};
        res1    = '{aetp_pkg::ACT_PRINT, i_char_byte, r_fg, 1'b1};
        case (r_state)
            ST_ESC: begin
                if (i_char_byte == aetp_pkg::CH_LBRACKET) begin
                    n_state = ST_CSI;
                    n_param = '0;
                end else begin
                    res0    = '{aetp_pkg::ACT_PRINT, aetp_pkg::CH_ESC, r_fg, 1'b0};
                    res_cnt = 2'd2;
                    n_state = ST_NORMAL;
                end
            end
            ST_CSI: begin
                if (i_char_byte inside {[aetp_pkg::CH_ZERO:aetp_pkg::CH_NINE]}) begin
                    n_param = (digit_sum > {4'd0, aetp_pkg::PARAM_MAX}) ?
                              aetp_pkg::PARAM_MAX : digit_sum[15:0];
                end else if (i_char_byte == aetp_pkg::CH_QUERY) begin
                    n_param = r_param;
                end else if (i_char_byte == aetp_pkg::CH_SEMI) begin
                    n_fg    = aetp_pkg::color_of(r_param);
                    n_param = '0;
                end else if (i_char_byte == aetp_pkg::CH_LOWER_M) begin
                    n_fg    = aetp_pkg::color_of(r_param);
                    n_param = '0;
                    n_state = ST_NORMAL;
                end else if (i_char_byte == aetp_pkg::CH_UPPER_J) begin
                    n_param = '0;
                    n_state = ST_NORMAL;
                    res0    = '{aetp_pkg::ACT_CLEAR, 8'd0, 32'd0, 1'b1};
                    res_cnt = (r_param == aetp_pkg::PARAM_CLEAR) ? 2'd1 : 2'd0;
                end else if (i_char_byte == aetp_pkg::CH_UPPER_H) begin
                    n_param = '0;
                    n_state = ST_NORMAL;
                    res0    = '{aetp_pkg::ACT_HOME, 8'd0, 32'd0, 1'b1};
                    res_cnt = 2'd1;
                end else begin
                    n_param = '0;
                    n_state = ST_NORMAL;
                end
            end
            default: begin
                n_state = ST_NORMAL;
                if (i_char_byte == aetp_pkg::CH_ESC) begin
                    n_state = ST_ESC;
                end else if (i_char_byte == aetp_pkg::CH_BS) begin
                    res0    = '{aetp_pkg::ACT_ERASE, 8'd0, r_erase, 1'b1};
                    res_cnt = 2'd1;
                end else begin
                    res_cnt = 2'd1;
                end
            end
        endcase
    end

    // shift out the head beat, then append new results behind what remains
    always_comb begin
        base  = r_cnt - CW'(pop);
        n_cnt = base + (accept ? CW'(res_cnt) : CW'(0));
        for (int k = 0; k < DEPTH - 1; k++) begin
            n_q[k] = pop ? r_q[k+1] : r_q[k];
        end
        n_q[DEPTH-1] = r_q[DEPTH-1];
        for (int k = 0; k < DEPTH; k++) begin
            if (accept && (res_cnt != 2'd0) && (CW'(k) == base)) begin
                n_q[k] = res0;
            end else if (accept && (res_cnt == 2'd2) && (CW'(k) == base + CW'(1))) begin
                n_q[k] = res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NORMAL;
            r_param <= '0;
            r_fg    <= aetp_pkg::COLOR_WHITE;
            r_erase <= aetp_pkg::ERASE_RESET;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_param <= n_param;
                r_fg    <= n_fg;
            end
            if (i_cfg_we) begin
                r_erase <= i_cfg_wdata;
            end
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    `AETP_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CW'(DEPTH))
    `AETP_ASSERT_NOW(a_pair_queued, o_out_valid && !o_last, r_cnt >= CW'(2))
    `AETP_ASSERT_NOW(a_param_in_csi, r_param != 16'd0, r_state == ST_CSI)
    `AETP_ASSERT_NEXT(a_esc_enter,
        accept && (r_state == ST_NORMAL) && (i_char_byte == aetp_pkg::CH_ESC),
        r_state == ST_ESC)

endmodule

// File: tb/terminal_action_checker.sv
// ============================================================================
// Terminal action checker
// Watches the byte and action channels of the parser and keeps its own model
// of the escape and CSI parse state, the foreground colour and the erase
// colour. Every accepted byte queues the action beats it should cause, and
// every accepted action beat is compared field by field with the oldest one.
// The failure count and the number of beats still owed go to the testbench.
// ============================================================================
module terminal_action_checker
    import aetp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_draw_color,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_owed_count
);

    typedef enum logic [1:0] {
        PS_TEXT   = 2'd0,
        PS_ESCAPE = 2'd1,
        PS_CSI    = 2'd2
    } t_parse_state;

    t_parse_state parse_st;
    logic [15:0]  csi_param;
    logic [31:0]  fg_col;
    logic [31:0]  erase_col;
    t_result      owed_actions[$];
    int           fails = 0;

    function automatic logic [31:0] sgr_color(input logic [15:0] code);
        case (code)
            16'd30:  return 32'hFF11_1111;
            16'd31:  return 32'hFFFF_5555;
            16'd32:  return 32'hFF55_FF55;
            16'd33:  return 32'hFFFF_FF55;
            16'd34:  return 32'hFF55_55FF;
            16'd35:  return 32'hFFFF_55FF;
            16'd36:  return 32'hFF55_FFFF;
            16'd90:  return 32'hFF88_8888;
            16'd91:  return 32'hFFFF_8888;
            16'd92:  return 32'hFF88_FF88;
            16'd93:  return 32'hFFFF_FF88;
            16'd94:  return 32'hFF88_88FF;
            16'd95:  return 32'hFFFF_88FF;
            16'd96:  return 32'hFF88_FFFF;
            default: return COLOR_WHITE;
        endcase
    endfunction

    function automatic t_result action_beat(input t_action act, input logic [7:0] ch,
                                            input logic [31:0] col, input logic fin);
        t_result r;
        r.action     = act;
        r.char_code  = ch;
        r.draw_color = col;
        r.last       = fin;
        return r;
    endfunction

    task automatic predict_actions(input logic [7:0] b);
        logic [31:0] acc;
        case (parse_st)
            PS_ESCAPE: begin
                if (b == CH_LBRACKET) begin
                    parse_st  = PS_CSI;
                    csi_param = '0;
                end else begin
                    owed_actions.push_back(action_beat(ACT_PRINT, CH_ESC, fg_col, 1'b0));
                    owed_actions.push_back(action_beat(ACT_PRINT, b, fg_col, 1'b1));
                    parse_st = PS_TEXT;
                end
            end
            PS_CSI: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    acc       = 32'(csi_param) * 32'd10 + 32'(b - CH_ZERO);
                    csi_param = (acc > 32'(PARAM_MAX)) ? PARAM_MAX : acc[15:0];
                end else if (b == CH_QUERY) begin
                end else if (b == CH_SEMI) begin
                    fg_col    = sgr_color(csi_param);
                    csi_param = '0;
                end else if (b == CH_LOWER_M) begin
                    fg_col    = sgr_color(csi_param);
                    csi_param = '0;
                    parse_st  = PS_TEXT;
                end else if (b == CH_UPPER_J) begin
                    if (csi_param == PARAM_CLEAR)
                        owed_actions.push_back(action_beat(ACT_CLEAR, 8'h00, 32'h0, 1'b1));
                    csi_param = '0;
                    parse_st  = PS_TEXT;
                end else if (b == CH_UPPER_H) begin
                    owed_actions.push_back(action_beat(ACT_HOME, 8'h00, 32'h0, 1'b1));
                    csi_param = '0;
                    parse_st  = PS_TEXT;
                end else begin
                    csi_param = '0;
                    parse_st  = PS_TEXT;
                end
            end
            default: begin
                parse_st = PS_TEXT;
                if (b == CH_ESC)
                    parse_st = PS_ESCAPE;
                else if (b == CH_BS)
                    owed_actions.push_back(action_beat(ACT_ERASE, 8'h00, erase_col, 1'b1));
                else
                    owed_actions.push_back(action_beat(ACT_PRINT, b, fg_col, 1'b1));
            end
        endcase
    endtask

    task automatic check_beat(input t_result got);
        t_result want;
        if (owed_actions.size() == 0) begin
            $error("unexpected action beat: action %0d char 0x%02h colour 0x%08h",
                   got.action, got.char_code, got.draw_color);
            fails++;
        end else begin
            want = owed_actions.pop_front();
            if (got.action !== want.action) begin
                $error("action: expected %0d, actual %0d", want.action, got.action);
                fails++;
            end
            if (got.char_code !== want.char_code) begin
                $error("char_code: expected 0x%02h, actual 0x%02h",
                       want.char_code, got.char_code);
                fails++;
            end
            if (got.draw_color !== want.draw_color) begin
                $error("draw_color: expected 0x%08h, actual 0x%08h",
                       want.draw_color, got.draw_color);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_st  = PS_TEXT;
            csi_param = '0;
            fg_col    = COLOR_WHITE;
            erase_col = ERASE_RESET;
            owed_actions.delete();
        end else begin
            if (i_cfg_we)
                erase_col = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                predict_actions(i_char_byte);
            if (i_out_valid && i_out_ready)
                check_beat({i_action, i_char_code, i_draw_color, i_last});
        end
        o_owed_count <= owed_actions.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/ansi_escape_terminal_parser_tb.sv
// ============================================================================
// Terminal parser testbench
// Drives the parser with a short directed run of plain, backspace, escape and
// CSI bytes, a back-pressure run, then phases of random well-formed and broken
// escape sequences under several erase colours. The sender mostly works in
// bursts, the receiver stalls on its own pattern; the checker compares.
// ============================================================================
module ansi_escape_terminal_parser_tb;
    import aetp_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASES          = 6;
    localparam int PHASE_BYTES     = 180;
    localparam int N_SGR           = 21;
    localparam int N_OPENING       = 27;

    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;

    localparam int SGR_CODES [N_SGR] = '{0, 2, 30, 31, 32, 33, 34, 35, 36, 37, 38,
                                         89, 90, 91, 92, 93, 94, 95, 96, 97, 98};

    localparam logic [7:0] OPENING [N_OPENING] = '{
        "A", 8'h00, 8'hFF, CH_BS,
        CH_ESC, "x",
        CH_ESC, CH_LBRACKET, "3", "1", CH_LOWER_M, "a",
        CH_ESC, CH_LBRACKET, "9", "4", CH_SEMI, "2", CH_UPPER_J,
        CH_ESC, CH_LBRACKET, CH_QUERY, CH_UPPER_H,
        CH_ESC, CH_LBRACKET, "5", CH_UPPER_J
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_char_byte = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_action;
    logic [7:0]  o_char_code;
    logic [31:0] o_draw_color;
    logic        o_last;

    int         fail_count;
    int         owed_count;
    int         idle_cycles  = 0;
    int         burst_left   = 0;
    bit         gaps_on      = 1'b1;
    logic       hold_off_req = 1'b0;
    bit         hold_seen    = 1'b0;
    int         hold_left    = 0;
    int         rx_cycles    = 0;
    int         rx_mode      = 0;
    logic [7:0] byte_stream[$];

    always #1 i_clk = ~i_clk;

    ansi_escape_terminal_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_byte  (i_char_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_action     (o_action),
        .o_char_code  (o_char_code),
        .o_draw_color (o_draw_color),
        .o_last       (o_last)
    );

    terminal_action_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_char_byte  (i_char_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_action     (o_action),
        .i_char_code  (o_char_code),
        .i_draw_color (o_draw_color),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_owed_count (owed_count)
    );

    always @(posedge i_clk) begin
        if (hold_off_req && !hold_seen)
            hold_left = HOLD_OFF_CYCLES;
        hold_seen = hold_off_req;
        if (rx_cycles == 0) begin
            rx_mode   = $urandom_range(3, 0);
            rx_cycles = $urandom_range(80, 16);
        end else begin
            rx_cycles--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(1, 0));
                2:       i_out_ready <= ($urandom_range(3, 0) != 0);
                default: i_out_ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
            burst_left = $urandom_range(24, 1);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (owed_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_erase_color(input logic [31:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic queue_sequence();
        int         pick;
        int         n_params;
        string      digits;
        logic [7:0] b;
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
            do b = 8'($urandom); while (b == CH_ESC);
            byte_stream.push_back(b);
        end else if (pick < 38) begin
            byte_stream.push_back(CH_BS);
        end else if (pick < 48) begin
            do b = 8'($urandom); while (b == CH_LBRACKET);
            byte_stream.push_back(CH_ESC);
            byte_stream.push_back(b);
        end else if (pick < 93) begin
            byte_stream.push_back(CH_ESC);
            byte_stream.push_back(CH_LBRACKET);
            if ($urandom_range(7, 0) == 0)
                byte_stream.push_back(CH_QUERY);
            n_params = $urandom_range(3, 0);
            for (int k = 0; k < n_params; k++) begin
                if (k > 0)
                    byte_stream.push_back(CH_SEMI);
                if ($urandom_range(5, 0) == 0)
                    digits = $sformatf("%0d", $urandom);
                else
                    digits = $sformatf("%0d", SGR_CODES[$urandom_range(N_SGR - 1, 0)]);
                for (int j = 0; j < digits.len(); j++)
                    byte_stream.push_back(digits[j]);
            end
            case ($urandom_range(5, 0))
                0, 1:    byte_stream.push_back(CH_LOWER_M);
                2:       byte_stream.push_back(CH_UPPER_J);
                3:       byte_stream.push_back(CH_UPPER_H);
                4:       byte_stream.push_back($urandom_range(1, 0) ? CH_LOWER_H : CH_LOWER_L);
                default: byte_stream.push_back(8'($urandom));
            endcase
        end else begin
            byte_stream.push_back(8'($urandom));
        end
    endtask

    initial begin
        int sent;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_OPENING; k++)
            send_byte(OPENING[k]);

        wait_drained();
        gaps_on = 1'b0;
        hold_off_req <= 1'b1;
        repeat (48) send_byte(8'($urandom_range(8'h7E, 8'h20)));
        hold_off_req <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            gaps_on = (p % 3 != 1);
            case (p)
                0:       write_erase_color(32'h0000_0000);
                1:       write_erase_color(32'hFFFF_FFFF);
                default: write_erase_color($urandom);
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                queue_sequence();
                while (byte_stream.size() != 0) begin
                    send_byte(byte_stream.pop_front());
                    sent++;
                end
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
